[hdl/erp_pkg.sv]
package erp_pkg;

  // input transaction
  typedef struct packed {
    logic        func;
    logic [31:0] pixel_in;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [31:0] pixel_out;
    logic [11:0] out_column;
    logic [12:0] out_row;
    logic        last;
  } out_t;

  // one classified source position, queued between front and back
  typedef struct packed {
    logic [31:0] pixel;
    logic [11:0] mid_column;  // padded column of the pixel itself
    logic [12:0] row;
    logic        left_edge;   // also emit the left guard pixel
    logic        right_edge;  // also emit the right guard pixel
    logic        final_mark;  // right guard pixel closes the image
  } job_t;

  // result sequencer states
  typedef enum logic [2:0] {
    PH_LEFT  = 3'b001,  // left guard pixel
    PH_MID   = 3'b010,  // the pixel itself
    PH_RIGHT = 3'b100   // right guard pixel
  } phase_t;

  // func codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int          GUARD        = 1;
  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;
  localparam int          FIFO_DEPTH   = 4;
  localparam int          FIFO_AW      = 2;

endpackage

[hdl/erp_front.sv]
module erp_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  erp_pkg::in_t                in_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [12:0]                 cfg_data,
  input  logic [erp_pkg::FIFO_AW:0]   fifo_count,
  output logic                        job_valid,
  output erp_pkg::job_t               job
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [11:0]   width_r;
  logic [12:0]   height_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [12:0]   row_r;
  logic [12:0]   row_nxt;
  logic          finished_r;
  logic          finished_nxt;

  logic [11:0]   w_eff;
  logic [11:0]   wm1;
  logic [CW-1:0] wm1_c;
  logic [12:0]   h_eff;
  logic [12:0]   last_row;
  logic [CW-1:0] col;
  logic [12:0]   row;
  logic [CW:0]   col_ext;
  logic          is_drain;
  logic          active;
  logic          take;
  logic          go;
  logic          at_right;
  logic          final_mark;

  logic [31:0]   line_mem [MAX_WIDTH];
  logic [31:0]   rd_r;

  logic          s1_valid_r;
  erp_pkg::job_t s1_job_r;
  logic          s1_src_r;

  logic [erp_pkg::FIFO_AW+1:0] level;

  // clamp the configured size to the supported range
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = 12'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = 12'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_r > erp_pkg::HEIGHT_LIMIT) begin
      h_eff = erp_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = height_r;
    end
  end

  assign wm1      = w_eff - 12'd1;
  assign wm1_c    = CW'(wm1);
  assign last_row = h_eff + 13'(2 * erp_pkg::GUARD - 1);

  // position of this transaction, clamped after a size change
  assign col = (col_r > wm1_c) ? wm1_c : col_r;
  assign row = (row_r > last_row) ? last_row : row_r;

  // classify: source pixels only while source rows remain, drain ticks after
  assign is_drain   = (in_data.func == erp_pkg::FUNC_DRAIN);
  assign active     = !finished_r && (is_drain ? (row_r >= h_eff) : (row_r < h_eff));
  assign take       = in_valid && !in_stall;
  assign go         = take && active;
  assign at_right   = (col == wm1_c);
  assign final_mark = is_drain && (row == last_row) && at_right;
  assign col_ext    = (CW+1)'(col) + (CW+1)'(erp_pkg::GUARD);

  // room check counts the job already in the read stage
  assign level    = (erp_pkg::FIFO_AW+2)'(fifo_count) + (erp_pkg::FIFO_AW+2)'(s1_valid_r);
  assign in_stall = (level >= (erp_pkg::FIFO_AW+2)'(erp_pkg::FIFO_DEPTH));

  // scan position update
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    finished_nxt = finished_r;
    if (go) begin
      if (at_right) begin
        col_nxt = '0;
        row_nxt = row + 13'd1;
      end else begin
        col_nxt = col + CW'(1);
        row_nxt = row;
      end
      if (final_mark) begin
        finished_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 12'd1;
      height_r   <= 13'd1;
      col_r      <= '0;
      row_r      <= '0;
      finished_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == erp_pkg::CFG_IMAGE_WIDTH)) begin
        width_r <= cfg_data[11:0];
      end
      if (cfg_we && (cfg_index == erp_pkg::CFG_IMAGE_HEIGHT)) begin
        height_r <= cfg_data;
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      finished_r <= finished_nxt;
      s1_valid_r <= go;
    end
  end

  // line store: previous row is read out as the arriving pixel replaces it
  always_ff @(posedge clk) begin
    if (go) begin
      rd_r <= line_mem[col];
      if (!is_drain) begin
        line_mem[col] <= in_data.pixel_in;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (go) begin
      s1_job_r.pixel      <= in_data.pixel_in;
      s1_job_r.mid_column <= 12'(col_ext);
      s1_job_r.row        <= row;
      s1_job_r.left_edge  <= (col == '0);
      s1_job_r.right_edge <= at_right;
      s1_job_r.final_mark <= final_mark;
      s1_src_r            <= !is_drain && (row == 13'd0);
    end
  end

  // top padded row comes from the source directly, others from the store
  always_comb begin
    job       = s1_job_r;
    job.pixel = s1_src_r ? s1_job_r.pixel : rd_r;
  end
  assign job_valid = s1_valid_r;

endmodule

[hdl/erp_fifo.sv]
module erp_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  erp_pkg::job_t             push_data,
  input  logic                      pop,
  output logic                      head_valid,
  output erp_pkg::job_t             head,
  output logic [erp_pkg::FIFO_AW:0] count
);

  erp_pkg::job_t                  entry_r [erp_pkg::FIFO_DEPTH];
  logic [erp_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [erp_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [erp_pkg::FIFO_AW:0]      count_r;
  logic [erp_pkg::FIFO_AW:0]      count_nxt;

  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign count      = count_r;

  // occupancy; the front never pushes into a full queue
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (erp_pkg::FIFO_AW+1)'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - (erp_pkg::FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + erp_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + erp_pkg::FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/erp_back.sv]
module erp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  erp_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output erp_pkg::out_t out_data
);

  // left guard, the pixel, right guard
  erp_pkg::phase_t phase_r;
  erp_pkg::phase_t phase_nxt;
  erp_pkg::phase_t phase;
  logic            done;
  logic            load;
  logic            out_valid_r;
  logic            out_valid_nxt;
  erp_pkg::out_t   out_r;
  erp_pkg::out_t   result;

  // skip the left guard unless the job sits on the left edge
  assign phase = ((phase_r == erp_pkg::PH_LEFT) && !head.left_edge) ? erp_pkg::PH_MID : phase_r;
  assign done  = (phase == erp_pkg::PH_RIGHT) ||
                 ((phase == erp_pkg::PH_MID) && !head.right_edge);
  assign load  = head_valid && (!out_valid_r || !out_stall);
  assign pop   = load && done;

  always_comb begin
    result.pixel_out = head.pixel;
    result.out_row   = head.row;
    result.last      = 1'b0;
    case (phase)
      erp_pkg::PH_LEFT: begin
        result.out_column = 12'd0;
      end
      erp_pkg::PH_MID: begin
        result.out_column = head.mid_column;
      end
      erp_pkg::PH_RIGHT: begin
        result.out_column = head.mid_column + 12'd1;
        result.last       = head.final_mark;
      end
      default: begin
        result.out_column = head.mid_column;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      if (done) begin
        phase_nxt = erp_pkg::PH_LEFT;
      end else if (phase == erp_pkg::PH_LEFT) begin
        phase_nxt = erp_pkg::PH_MID;
      end else begin
        phase_nxt = erp_pkg::PH_RIGHT;
      end
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= erp_pkg::PH_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/edge_replicate_pad_stream.sv]
// An accepted input passes the read stage, the queue and the output register before its
// first result is valid. One input per cycle for interior pixels while out_stall is low and
// the queue has room; an edge pixel gives two results (three at width one) to the single port.
// Reset (synchronous, rst_n low): scan position, done flag and queue cleared,
// image size registers return to 1 x 1; the line store is not cleared.
module edge_replicate_pad_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  erp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output erp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data
);

  logic                      job_valid;
  erp_pkg::job_t             job;
  logic                      head_valid;
  erp_pkg::job_t             head;
  logic                      pop;
  logic [erp_pkg::FIFO_AW:0] fifo_count;

  // classify, track position, read and refresh the line store
  erp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_count (fifo_count),
    .job_valid  (job_valid),
    .job        (job)
  );

  // decoupling queue
  erp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_data  (job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (fifo_count)
  );

  // expand each job into its one to three padded pixels
  erp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
